@@ rtl/srt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package srt_pkg;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_MODIFY = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // One stored record: key and three scores, 56 bits
    typedef struct packed {
        logic [31:0] key;
        logic [7:0]  score_one;
        logic [7:0]  score_two;
        logic [7:0]  score_three;
    } t_record;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load_in;
        logic       search_en;
        logic       pos_take;
        logic       shift_up_init;
        logic       shift_down_init;
        logic       shift_en;
        logic       place_en;
        logic       count_inc;
        logic       count_dec;
        logic       load_out;
        logic [1:0] status;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cmd_insert;
        logic cmd_modify;
        logic cmd_delete;
        logic hit_eq;
        logic hit_gt;
        logic exhausted;
        logic full;
        logic shift_done;
    } t_dp_status;

endpackage
`default_nettype wire

@@ rtl/srt_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface srt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] record_key;
    logic [7:0]  score_one;
    logic [7:0]  score_two;
    logic [7:0]  score_three;

    modport source (
        output valid, command, record_key, score_one, score_two, score_three,
        input  ready
    );
    modport sink (
        input  valid, command, record_key, score_one, score_two, score_three,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/srt_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface srt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] position;
    logic [6:0] entry_count;

    modport source (
        output valid, status, position, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, position, entry_count,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/srt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module srt_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire srt_pkg::t_dp_cmd   i_cmd,
    output srt_pkg::t_dp_status     o_st,
    input  wire logic [1:0]         i_command,
    input  wire logic [31:0]        i_record_key,
    input  wire logic [7:0]         i_score_one,
    input  wire logic [7:0]         i_score_two,
    input  wire logic [7:0]         i_score_three,
    output logic [1:0]              o_status,
    output logic [5:0]              o_position,
    output logic [6:0]              o_entry_count
);
    import srt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // Record memory, one read and one write port
    t_record r_mem [TABLE_DEPTH];
    t_record r_rd;

    // Captured command
    logic [1:0]    r_command;
    logic [31:0]   r_key;
    logic [7:0]    r_s1;
    logic [7:0]    r_s2;
    logic [7:0]    r_s3;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_pos;

    // Search pipeline
    logic [CW-1:0] r_idx;
    logic          r_rv;
    logic [IW-1:0] r_ridx;

    // Shift pipeline
    logic [CW-1:0] r_sidx;
    logic          r_sup;
    logic          r_wv;
    logic [IW-1:0] r_widx;

    // Result registers
    logic [1:0]    r_o_status;
    logic [CW-1:0] r_o_pos;
    logic [CW-1:0] r_o_count;

    logic          w_srch_issue;
    logic          w_shift_issue;
    logic [CW-1:0] w_limit;
    logic [CW-1:0] w_src;
    logic [CW-1:0] w_dst;
    logic          w_rd_en;
    logic [IW-1:0] w_rd_addr;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_addr;
    t_record       w_wr_data;
    logic          w_eq;
    logic          w_gt;
    logic [CW-1:0] w_pos;

    // Compare the record read last cycle against the key
    assign w_eq  = r_rv && (r_rd.key == r_key);
    assign w_gt  = r_rv && (r_rd.key > r_key);
    assign w_pos = (w_eq || w_gt) ? CW'(r_ridx) : r_count;

    assign w_srch_issue = i_cmd.search_en && (r_idx < r_count);

    // Shift addressing: up moves entry s-1 to s, down moves entry s to s-1
    assign w_limit       = r_sup ? r_pos : r_count;
    assign w_shift_issue = i_cmd.shift_en && (r_sidx != w_limit);
    assign w_src         = r_sup ? (r_sidx - ONE_C) : r_sidx;
    assign w_dst         = r_sup ? r_sidx : (r_sidx - ONE_C);

    // Read port select
    always_comb begin
        w_rd_en   = w_srch_issue || w_shift_issue;
        w_rd_addr = w_shift_issue ? w_src[IW-1:0] : r_idx[IW-1:0];
    end

    // Write port select: shift write-back or record placement
    always_comb begin
        w_wr_en   = r_wv || i_cmd.place_en;
        w_wr_addr = r_wv ? r_widx : r_pos[IW-1:0];
        w_wr_data = r_wv ? r_rd : t_record'{key: r_key, score_one: r_s1,
                                             score_two: r_s2, score_three: r_s3};
    end

    // Memory access
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // Capture the transaction fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_command <= i_command;
            r_key     <= i_record_key;
            r_s1      <= i_score_one;
            r_s2      <= i_score_two;
            r_s3      <= i_score_three;
        end
    end

    // Search index and read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv  <= 1'b0;
            r_idx <= '0;
        end else begin
            r_rv <= w_srch_issue;
            if (i_cmd.load_in) begin
                r_idx <= '0;
            end else if (w_srch_issue) begin
                r_idx <= r_idx + ONE_C;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_srch_issue) begin
            r_ridx <= r_idx[IW-1:0];
        end
        if (i_cmd.pos_take) begin
            r_pos <= w_pos;
        end
    end

    // Shift index and write-back tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
        end else begin
            r_wv <= w_shift_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_up_init) begin
            r_sup  <= 1'b1;
            r_sidx <= r_count;
        end else if (i_cmd.shift_down_init) begin
            r_sup  <= 1'b0;
            r_sidx <= w_pos + ONE_C;
        end else if (w_shift_issue) begin
            r_sidx <= r_sup ? (r_sidx - ONE_C) : (r_sidx + ONE_C);
        end
        if (w_shift_issue) begin
            r_widx <= w_dst[IW-1:0];
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.count_inc) begin
            r_count <= r_count + ONE_C;
        end else if (i_cmd.count_dec) begin
            r_count <= r_count - ONE_C;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status <= i_cmd.status;
            r_o_pos    <= (i_cmd.status == ST_OK) ? r_pos : '0;
            r_o_count  <= r_count;
        end
    end

    assign o_status      = r_o_status;
    assign o_position    = 6'(32'(r_o_pos));
    assign o_entry_count = 7'(32'(r_o_count));

    // Status to the controller
    always_comb begin
        o_st.cmd_insert = (r_command == CMD_INSERT);
        o_st.cmd_modify = (r_command == CMD_MODIFY);
        o_st.cmd_delete = (r_command == CMD_DELETE);
        o_st.hit_eq     = w_eq;
        o_st.hit_gt     = w_gt;
        o_st.exhausted  = !r_rv && (r_idx == r_count);
        o_st.full       = (r_count >= DEPTH_C);
        o_st.shift_done = (r_sidx == w_limit) && !r_wv;
    end

endmodule
`default_nettype wire

@@ rtl/srt_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
module srt_controller (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cmd_valid,
    output logic                     o_cmd_ready,
    output logic                     o_rsp_valid,
    input  wire logic                i_rsp_ready,
    input  wire srt_pkg::t_dp_status i_st,
    output srt_pkg::t_dp_cmd         o_dp
);
    import srt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_PLACE  = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_status;
    logic [1:0] n_status;
    logic       r_valid;
    logic       n_valid;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_valid;

    // Sequence one transaction: search, optional shift, optional placement, result
    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_valid     = r_valid && !i_rsp_ready;
        o_dp        = '0;
        o_dp.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_dp.load_in = 1'b1;
                    n_state      = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_dp.search_en = 1'b1;
                if (i_st.cmd_insert) begin
                    if (i_st.hit_eq) begin
                        n_status = ST_DUP;
                        n_state  = S_RESP;
                    end else if (i_st.hit_gt || i_st.exhausted) begin
                        if (i_st.full) begin
                            n_status = ST_FULL;
                            n_state  = S_RESP;
                        end else begin
                            o_dp.pos_take      = 1'b1;
                            o_dp.shift_up_init = 1'b1;
                            n_state            = S_SHIFT;
                        end
                    end
                end else if (i_st.cmd_modify || i_st.cmd_delete) begin
                    if (i_st.hit_eq) begin
                        o_dp.pos_take = 1'b1;
                        if (i_st.cmd_delete) begin
                            o_dp.shift_down_init = 1'b1;
                            n_state              = S_SHIFT;
                        end else begin
                            n_state = S_PLACE;
                        end
                    end else if (i_st.hit_gt || i_st.exhausted) begin
                        n_status = ST_MISSING;
                        n_state  = S_RESP;
                    end
                end else begin
                    // Unused command code: report a missing key
                    n_status = ST_MISSING;
                    n_state  = S_RESP;
                end
            end
            S_SHIFT: begin
                o_dp.shift_en = 1'b1;
                if (i_st.shift_done) begin
                    if (i_st.cmd_insert) begin
                        n_state = S_PLACE;
                    end else begin
                        o_dp.count_dec = 1'b1;
                        n_status       = ST_OK;
                        n_state        = S_RESP;
                    end
                end
            end
            S_PLACE: begin
                o_dp.place_en  = 1'b1;
                o_dp.count_inc = i_st.cmd_insert;
                n_status       = ST_OK;
                n_state        = S_RESP;
            end
            S_RESP: begin
                // Hold until the result register is free
                if (!r_valid || i_rsp_ready) begin
                    o_dp.load_out = 1'b1;
                    n_valid       = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_valid  <= n_valid;
        end
    end

endmodule
`default_nettype wire

@@ rtl/sorted_record_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sorted record table: holds up to TABLE_DEPTH records (32-bit key, three
// 8-bit scores) in ascending key order in a single-port-read, single-port-
// write memory. Each command transaction (insert, modify, delete) returns one
// result with status, position and the count after the command. One command
// is worked on at a time; a new command is taken while the previous result
// still waits in the output register. The memory reads and writes one record
// per cycle: a search reads the occupied entries up to the match or the
// first larger key, an insert or delete then moves each following record
// once, an insert or modify places the record, and the result is loaded
// into the output register once it is free of the previous result. The
// search stops where the shift starts. The memory needs no clearing after
// reset; the table starts empty.
module sorted_record_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    srt_cmd_if.sink    i_cmd,
    srt_rsp_if.source  o_rsp
);
    import srt_pkg::*;

    t_dp_cmd    w_dp_cmd;
    t_dp_status w_dp_st;
    logic       w_cmd_ready;
    logic       w_rsp_valid;
    logic [1:0] w_status;
    logic [5:0] w_position;
    logic [6:0] w_entry_count;

    srt_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (w_cmd_ready),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .i_st        (w_dp_st),
        .o_dp        (w_dp_cmd)
    );

    srt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_dp_cmd),
        .o_st          (w_dp_st),
        .i_command     (i_cmd.command),
        .i_record_key  (i_cmd.record_key),
        .i_score_one   (i_cmd.score_one),
        .i_score_two   (i_cmd.score_two),
        .i_score_three (i_cmd.score_three),
        .o_status      (w_status),
        .o_position    (w_position),
        .o_entry_count (w_entry_count)
    );

    assign i_cmd.ready       = w_cmd_ready;
    assign o_rsp.valid       = w_rsp_valid;
    assign o_rsp.status      = w_status;
    assign o_rsp.position    = w_position;
    assign o_rsp.entry_count = w_entry_count;

endmodule
`default_nettype wire

@@ bench/tb_sorted_record_table_unit.sv @@
`timescale 1ns / 1ps
module tb_sorted_record_table_unit;
    import srt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int POOL_SIZE   = 128;
    // allow some slack on top of the slowest command
    localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 24;
    // the command code with no meaning
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  command;
        logic [31:0] record_key;
        logic [7:0]  score_one;
        logic [7:0]  score_two;
        logic [7:0]  score_three;
        bit          settle_first;
    } table_cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] position;
        logic [6:0] entry_count;
    } table_outcome_t;

    logic i_clk;
    logic i_rst_n;

    srt_cmd_if cmd_bus ();
    srt_rsp_if rsp_bus ();

    sorted_record_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    // shadow copy of the table, kept in key order
    t_record        shadow_table [TABLE_DEPTH];
    int             shadow_fill = 0;
    table_cmd_t     queued_cmds [$];
    table_outcome_t awaited_outcomes [$];
    int             n_issued = 0;
    int             n_checked = 0;
    int             mismatches = 0;
    int             burst_left = 0;
    int             gap_left = 0;
    logic [15:0]    ready_pattern = '1;
    logic [3:0]     ready_step = '0;
    logic [31:0]    key_pool [POOL_SIZE];
    int             pool_order [POOL_SIZE];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one accepted command to the shadow table and queue its outcome
    task automatic apply_command(input table_cmd_t c);
        table_outcome_t r;
        int  slot;
        int  i;
        bit  seen;
        bit  done;
        r.status   = ST_MISSING;
        r.position = '0;
        case (c.command)
            CMD_INSERT: begin
                slot = shadow_fill;
                seen = 1'b0;
                done = 1'b0;
                // stop at an equal key or at the first larger one
                for (i = 0; i < shadow_fill; i++) begin
                    if (!done && shadow_table[i].key == c.record_key) begin
                        seen = 1'b1;
                        done = 1'b1;
                    end else if (!done && shadow_table[i].key > c.record_key) begin
                        slot = i;
                        done = 1'b1;
                    end
                end
                if (seen) begin
                    r.status = ST_DUP;
                end else if (shadow_fill >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = shadow_fill; i > slot; i--)
                        shadow_table[i] = shadow_table[i - 1];
                    shadow_table[slot] = {c.record_key, c.score_one, c.score_two,
                                          c.score_three};
                    shadow_fill++;
                    r.status   = ST_OK;
                    r.position = slot[5:0];
                end
            end
            CMD_MODIFY, CMD_DELETE: begin
                slot = -1;
                for (i = 0; i < shadow_fill; i++) begin
                    if (slot < 0 && shadow_table[i].key == c.record_key)
                        slot = i;
                end
                if (slot >= 0) begin
                    if (c.command == CMD_MODIFY) begin
                        shadow_table[slot].score_one   = c.score_one;
                        shadow_table[slot].score_two   = c.score_two;
                        shadow_table[slot].score_three = c.score_three;
                    end else begin
                        for (i = slot; i + 1 < shadow_fill; i++)
                            shadow_table[i] = shadow_table[i + 1];
                        shadow_fill--;
                    end
                    r.status   = ST_OK;
                    r.position = slot[5:0];
                end
            end
            default: begin
                // unused command: nothing changes, reported as a missing key
            end
        endcase
        r.entry_count = shadow_fill[6:0];
        awaited_outcomes.push_back(r);
    endtask

    task automatic add_cmd(input logic [1:0] op, input logic [31:0] key,
                           input logic [7:0] s1, input logic [7:0] s2,
                           input logic [7:0] s3, input bit settle);
        table_cmd_t c;
        c.command      = op;
        c.record_key   = key;
        c.score_one    = s1;
        c.score_two    = s2;
        c.score_three  = s3;
        c.settle_first = settle;
        queued_cmds.push_back(c);
    endtask

    task automatic shuffle_pool();
        int i;
        int j;
        int t;
        for (i = POOL_SIZE - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = pool_order[i];
            pool_order[i] = pool_order[j];
            pool_order[j] = t;
        end
    endtask

    // Command driver: bursts of random length with random gaps
    always @(posedge i_clk) begin : drive_cmds
        table_cmd_t head;
        bit         took;
        bit         present;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            took = cmd_bus.valid && cmd_bus.ready;
            if (took) begin
                apply_command(queued_cmds.pop_front());
                n_issued <= n_issued + 1;
                if (burst_left > 0)
                    burst_left--;
            end
            if (cmd_bus.valid && !cmd_bus.ready) begin
                // hold the offered transaction
                present = 1'b1;
            end else begin
                present = 1'b0;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (queued_cmds.size() != 0) begin
                    head = queued_cmds[0];
                    // a settle point waits until every result has come back
                    if (!head.settle_first || (!took && n_issued == n_checked)) begin
                        present = 1'b1;
                        cmd_bus.command     <= head.command;
                        cmd_bus.record_key  <= head.record_key;
                        cmd_bus.score_one   <= head.score_one;
                        cmd_bus.score_two   <= head.score_two;
                        cmd_bus.score_three <= head.score_three;
                    end
                end
            end
            cmd_bus.valid <= present;
        end
    end

    // Result monitor with its own stall pattern on ready
    always @(posedge i_clk) begin : watch_results
        table_outcome_t want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                n_checked <= n_checked + 1;
                if (awaited_outcomes.size() == 0) begin
                    $display("%0t: unexpected result: status %0d position %0d count %0d",
                             $time, rsp_bus.status, rsp_bus.position,
                             rsp_bus.entry_count);
                    mismatches++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (rsp_bus.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_bus.status);
                        mismatches++;
                    end
                    if (rsp_bus.position !== want.position) begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, rsp_bus.position);
                        mismatches++;
                    end
                    if (rsp_bus.entry_count !== want.entry_count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, rsp_bus.entry_count);
                        mismatches++;
                    end
                end
            end
            rsp_bus.ready <= ready_pattern[ready_step];
            if (ready_step == 4'd15) begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = 16'($urandom);
                    2:       ready_pattern = 16'($urandom | $urandom);
                    default: ready_pattern = 16'($urandom & $urandom);
                endcase
            end
            ready_step = ready_step + 4'd1;
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        logic [31:0] hi;
        logic [31:0] key;
        logic [1:0]  op;
        int          rnd;
        int          i;
        int          pick;

        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.command      = CMD_INSERT;
        cmd_bus.record_key   = '0;
        cmd_bus.score_one    = '0;
        cmd_bus.score_two    = '0;
        cmd_bus.score_three  = '0;
        rsp_bus.ready        = 1'b0;

        // directed: empty table, front, middle and end placement, misses
        add_cmd(CMD_DELETE, 32'd5, 8'h00, 8'h00, 8'h00, 1'b0);
        add_cmd(CMD_MODIFY, 32'd5, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_cmd(CMD_INSERT, 32'd1000, 8'h00, 8'h00, 8'h00, 1'b0);
        add_cmd(CMD_INSERT, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_cmd(CMD_INSERT, 32'hFFFF_FFFF, 8'h80, 8'h7F, 8'h01, 1'b0);
        add_cmd(CMD_INSERT, 32'd500, 8'h55, 8'hAA, 8'h0F, 1'b0);
        add_cmd(CMD_INSERT, 32'd1000, 8'h11, 8'h22, 8'h33, 1'b0);
        add_cmd(CMD_MODIFY, 32'd500, 8'hA5, 8'h5A, 8'h3C, 1'b0);
        add_cmd(CMD_MODIFY, 32'd7, 8'h01, 8'h02, 8'h03, 1'b0);
        add_cmd(CMD_UNUSED, 32'd500, 8'h00, 8'h00, 8'h00, 1'b0);
        add_cmd(CMD_DELETE, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 1'b0);
        add_cmd(CMD_DELETE, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 1'b0);
        add_cmd(CMD_DELETE, 32'd12345, 8'h00, 8'h00, 8'h00, 1'b0);
        add_cmd(CMD_INSERT, 32'h8000_0000, 8'h80, 8'h80, 8'h80, 1'b0);
        add_cmd(CMD_DELETE, 32'd500, 8'h00, 8'h00, 8'h00, 1'b0);
        add_cmd(CMD_DELETE, 32'd1000, 8'h00, 8'h00, 8'h00, 1'b0);
        add_cmd(CMD_DELETE, 32'h8000_0000, 8'h00, 8'h00, 8'h00, 1'b0);
        add_cmd(CMD_DELETE, 32'h8000_0000, 8'h00, 8'h00, 8'h00, 1'b0);

        // random rounds: fill to full, churn, then drain
        for (rnd = 0; rnd < 2; rnd++) begin
            // low seven bits carry the index, so pool keys never collide
            for (i = 0; i < POOL_SIZE; i++) begin
                hi = (rnd == 0) ? $urandom : $urandom_range(0, 3);
                key_pool[i]   = {hi[24:0], i[6:0]};
                pool_order[i] = i;
            end
            if (rnd == 0) begin
                key_pool[0]             = '0;
                key_pool[POOL_SIZE - 1] = '1;
            end
            shuffle_pool();
            for (i = 0; i < TABLE_DEPTH; i++)
                add_cmd(CMD_INSERT, key_pool[pool_order[i]], 8'($urandom), 8'($urandom),
                        8'($urandom), i == 0);
            // table full now: fresh keys and stored keys
            for (i = 0; i < 6; i++)
                add_cmd(CMD_INSERT, key_pool[pool_order[TABLE_DEPTH + i]], 8'($urandom),
                        8'($urandom), 8'($urandom), 1'b0);
            for (i = 0; i < 4; i++)
                add_cmd(CMD_INSERT, key_pool[pool_order[$urandom_range(0, TABLE_DEPTH - 1)]],
                        8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
            for (i = 0; i < 220; i++) begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 3) == 0)
                    key = $urandom;
                else
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                if (pick < 35)
                    op = CMD_INSERT;
                else if (pick < 60)
                    op = CMD_MODIFY;
                else if (pick < 93)
                    op = CMD_DELETE;
                else
                    op = CMD_UNUSED;
                add_cmd(op, key, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
            end
            shuffle_pool();
            for (i = 0; i < POOL_SIZE; i++)
                add_cmd(CMD_DELETE, key_pool[pool_order[i]], 8'($urandom), 8'($urandom),
                        8'($urandom), i == 0);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_cmds.size() != 0 || awaited_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin : watchdog
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sorted_record_table_unit.f @@
rtl/srt_pkg.sv
rtl/srt_cmd_if.sv
rtl/srt_rsp_if.sv
rtl/srt_datapath.sv
rtl/srt_controller.sv
rtl/sorted_record_table_unit.sv
bench/tb_sorted_record_table_unit.sv
